// File: design/sadc_pkg.sv
// ----------------------------------------------------------------------------
// sadc_pkg
// Shared types, constants and character tables for the serial alphanumeric
// display controller.
// ----------------------------------------------------------------------------
package sadc_pkg;

  localparam int DIGIT_POSITIONS = 16;
  localparam int POS_W           = 4;
  localparam int CHAR_W          = 6;
  localparam int LEVEL_W         = 5;
  localparam int SEG_W           = 16;

  localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 6'd32;
  localparam logic [CHAR_W-1:0]  MARK_RESET   = 6'd0;
  localparam logic [CHAR_W-1:0]  MARK_PLAIN   = 6'd6;
  localparam logic [CHAR_W-1:0]  MARK_COMMA   = 6'd44;
  localparam logic [CHAR_W-1:0]  MARK_DOT     = 6'd46;
  localparam logic [LEVEL_W-1:0] DIGITS_RESET = 5'd16;
  localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 5'd31;
  localparam logic [3:0]         NIB_WRAP     = 4'd15;
  localparam logic [2:0]         LAST_BIT     = 3'd7;

  // control byte function, bits 6:5
  localparam logic [1:0] CTL_TEST   = 2'b00;
  localparam logic [1:0] CTL_CURSOR = 2'b01;
  localparam logic [1:0] CTL_DIGITS = 2'b10;
  localparam logic [1:0] CTL_BRIGHT = 2'b11;

  typedef struct packed {
    logic               last_clock;
    logic [2:0]         bit_count;
    logic [7:0]         shift;
    logic [POS_W-1:0]   cursor;
    logic [POS_W-1:0]   prev_cursor;
    logic [LEVEL_W-1:0] digit_total;
    logic [LEVEL_W-1:0] bright;
  } sadc_state_t;

  typedef struct packed {
    logic              char_we;
    logic [POS_W-1:0]  char_addr;
    logic [CHAR_W-1:0] char_data;
    logic              mark_we;
    logic [POS_W-1:0]  mark_addr;
    logic [CHAR_W-1:0] mark_data;
  } sadc_wr_t;

  localparam logic [CHAR_W-1:0] CHAR_REMAP [64] = '{
     6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,
     6'd8,  6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
    6'd24, 6'd25, 6'd26, 6'd32, 6'd28, 6'd32, 6'd32, 6'd31,
    6'd32, 6'd32, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
    6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47,
    6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55,
    6'd56, 6'd56, 6'd57, 6'd58, 6'd59, 6'd60, 6'd61, 6'd62
  };

  localparam logic [SEG_W-1:0] SEG_ROM [64] = '{
    16'd20607, 16'd17615,  16'd5439,   16'd243,  16'd4415, 16'd16627, 16'd16579,  16'd1275,
    16'd17612,  16'd4403,   16'd124, 16'd19136,   16'd240, 16'd33484, 16'd35020,   16'd255,
    16'd17607,  16'd2303, 16'd19655, 16'd17595,  16'd4355,   16'd252,  16'd8896, 16'd10444,
    16'd43520, 16'd37376,  16'd8755,   16'd225, 16'd34816,    16'd30, 16'd10240,    16'd48,
        16'd0, 16'd33057,   16'd384, 16'd21820,  16'd4539, 16'd30617, 16'd51577,   16'd512,
     16'd2560, 16'd40960, 16'd65280, 16'd21760,     16'd0, 16'd17408,     16'd0,  16'd8704,
     16'd8959,  16'd4352, 16'd17527, 16'd17471, 16'd17548, 16'd17595, 16'd17659,    16'd15,
    16'd17663, 16'd17599,    16'd33,  16'd8193, 16'd17456, 16'd17456,   16'd786,  16'd5127
  };

endpackage

// File: design/sadc_byte_exec.sv
// ----------------------------------------------------------------------------
// sadc_byte_exec
// Serial receiver step and byte decoder: next register state and the store
// write requests for one sample of the serial lines.
// ----------------------------------------------------------------------------
module sadc_byte_exec
  import sadc_pkg::*;
(
  input  sadc_state_t st,
  input  logic        reset_line,
  input  logic        clock_line,
  input  logic        data_line,
  output sadc_state_t st_nxt,
  output sadc_wr_t    wr,
  output logic        took
);

  logic [7:0]        sh_or;
  logic [CHAR_W-1:0] low6;
  logic [3:0]        nib;

  assign sh_or = st.shift | {7'b0, data_line};
  assign low6  = sh_or[CHAR_W-1:0];
  assign nib   = sh_or[3:0];

  always_comb begin
    st_nxt = st;
    wr     = '0;
    took   = 1'b0;
    if (!reset_line) begin
      st_nxt.last_clock  = clock_line;
      st_nxt.bit_count   = '0;
      st_nxt.shift       = '0;
      st_nxt.cursor      = '0;
      st_nxt.prev_cursor = '0;
      st_nxt.digit_total = DIGITS_RESET;
      st_nxt.bright      = BRIGHT_RESET;
    end else begin
      if (st.last_clock && !clock_line) begin
        if (st.bit_count == LAST_BIT) begin
          st_nxt.bit_count = '0;
          st_nxt.shift     = '0;
          took             = 1'b1;
          if (!sh_or[7]) begin
            if (low6 == MARK_COMMA || low6 == MARK_DOT) begin
              // attach the mark to the previous cursor position
              wr.mark_we   = 1'b1;
              wr.mark_addr = st.prev_cursor;
              wr.mark_data = low6;
            end else begin
              wr.char_we         = 1'b1;
              wr.char_addr       = st.cursor;
              wr.char_data       = low6;
              wr.mark_we         = 1'b1;
              wr.mark_addr       = st.cursor;
              wr.mark_data       = MARK_PLAIN;
              st_nxt.prev_cursor = st.cursor;
              st_nxt.cursor      = st.cursor + 1'b1;
            end
          end else begin
            case (sh_or[6:5])
              CTL_CURSOR: begin
                st_nxt.prev_cursor = st.cursor;
                st_nxt.cursor      = (nib == NIB_WRAP) ? '0 : nib + 1'b1;
              end
              CTL_DIGITS: begin
                st_nxt.digit_total = (nib == 4'd0) ? DIGITS_RESET : {1'b0, nib};
              end
              CTL_BRIGHT: begin
                st_nxt.bright = sh_or[LEVEL_W-1:0];
              end
              default: begin
                // test mode: ignore
              end
            endcase
          end
        end else begin
          st_nxt.bit_count = st.bit_count + 1'b1;
          st_nxt.shift     = {sh_or[6:0], 1'b0};
        end
      end
      st_nxt.last_clock = clock_line;
    end
  end

endmodule

// File: design/serial_alphanumeric_display_controller.sv
// ----------------------------------------------------------------------------
// serial_alphanumeric_display_controller
// Serial-line 16-segment display controller with character and mark stores
// and per-sample read-back of one digit position.
// ----------------------------------------------------------------------------
// One transaction is accepted every clock cycle unless the output stalls;
// each gives one result from a registered store read, then character remap
// and segment ROM lookup into the output register. Character and mark
// stores are 16-entry synchronous memories with one write and one read per
// cycle; a write and a read of the same position in one transaction are
// resolved by forwarding. Per-entry valid bits make unwritten positions
// read as a space with no mark after rst_n, so no clearing pass is needed.
// The reset_line input restarts the receiver and the settings but keeps the stores.
module serial_alphanumeric_display_controller
  import sadc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_reset_line,
  input  logic               in_clock_line,
  input  logic               in_data_line,
  input  logic [POS_W-1:0]   in_read_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SEG_W-1:0]   out_segment_pattern,
  output logic [CHAR_W-1:0]  out_point_mark,
  output logic [LEVEL_W-1:0] out_bright_level,
  output logic [LEVEL_W-1:0] out_digits_in_use,
  output logic               out_byte_taken
);

  sadc_state_t st_r, st_nxt;
  sadc_wr_t    wr;
  logic        took;
  logic        in_fire, s1_adv;

  logic [CHAR_W-1:0] char_mem [DIGIT_POSITIONS];
  logic [CHAR_W-1:0] mark_mem [DIGIT_POSITIONS];
  logic [DIGIT_POSITIONS-1:0] char_vld_r, mark_vld_r;

  logic               s1_vld_r;
  logic [CHAR_W-1:0]  s1_char_rd_r, s1_mark_rd_r;
  logic               s1_char_ok_r, s1_mark_ok_r;
  logic               s1_char_hit_r, s1_mark_hit_r;
  logic [CHAR_W-1:0]  s1_char_wd_r, s1_mark_wd_r;
  logic [LEVEL_W-1:0] s1_bright_r, s1_digits_r;
  logic               s1_took_r;
  logic [CHAR_W-1:0]  s1_char, s1_mark;

  logic               out_vld_r;
  logic [SEG_W-1:0]   out_seg_r;
  logic [CHAR_W-1:0]  out_mark_r;
  logic [LEVEL_W-1:0] out_bright_r, out_digits_r;
  logic               out_took_r;

  sadc_byte_exec u_exec (
    .st         (st_r),
    .reset_line (in_reset_line),
    .clock_line (in_clock_line),
    .data_line  (in_data_line),
    .st_nxt     (st_nxt),
    .wr         (wr),
    .took       (took)
  );

  assign s1_adv   = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.last_clock  <= 1'b0;
      st_r.bit_count   <= '0;
      st_r.shift       <= '0;
      st_r.cursor      <= '0;
      st_r.prev_cursor <= '0;
      st_r.digit_total <= DIGITS_RESET;
      st_r.bright      <= BRIGHT_RESET;
      char_vld_r       <= '0;
      mark_vld_r       <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
      if (wr.char_we) begin
        char_vld_r[wr.char_addr] <= 1'b1;
      end
      if (wr.mark_we) begin
        mark_vld_r[wr.mark_addr] <= 1'b1;
      end
    end
  end

  // stores: read old data at the accept edge, forward this transaction's write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_rd_r <= char_mem[in_read_position];
      s1_mark_rd_r <= mark_mem[in_read_position];
      if (wr.char_we) begin
        char_mem[wr.char_addr] <= wr.char_data;
      end
      if (wr.mark_we) begin
        mark_mem[wr.mark_addr] <= wr.mark_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_ok_r  <= char_vld_r[in_read_position];
      s1_mark_ok_r  <= mark_vld_r[in_read_position];
      s1_char_hit_r <= wr.char_we && (wr.char_addr == in_read_position);
      s1_mark_hit_r <= wr.mark_we && (wr.mark_addr == in_read_position);
      s1_char_wd_r  <= wr.char_data;
      s1_mark_wd_r  <= wr.mark_data;
      s1_bright_r   <= st_nxt.bright;
      s1_digits_r   <= st_nxt.digit_total;
      s1_took_r     <= took;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  assign s1_char = s1_char_hit_r ? s1_char_wd_r :
                   (s1_char_ok_r ? s1_char_rd_r : CHAR_SPACE);
  assign s1_mark = s1_mark_hit_r ? s1_mark_wd_r :
                   (s1_mark_ok_r ? s1_mark_rd_r : MARK_RESET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) begin
      out_seg_r    <= SEG_ROM[CHAR_REMAP[s1_char]];
      out_mark_r   <= s1_mark;
      out_bright_r <= s1_bright_r;
      out_digits_r <= s1_digits_r;
      out_took_r   <= s1_took_r;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_segment_pattern = out_seg_r;
  assign out_point_mark      = out_mark_r;
  assign out_bright_level    = out_bright_r;
  assign out_digits_in_use   = out_digits_r;
  assign out_byte_taken      = out_took_r;

`ifndef NO_ASSERTIONS
  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_reset_line |=> st_r.bit_count == '0 && st_r.cursor == '0
      && st_r.digit_total == DIGITS_RESET)
    else $error("line reset did not restore receiver and settings");

  a_digits_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.digit_total != '0 && st_r.digit_total <= DIGITS_RESET)
    else $error("digit count out of range");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_vld_r && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline is full");

  a_char_with_mark: assert property (@(posedge clk) disable iff (!rst_n)
    wr.char_we |-> wr.mark_we && wr.mark_addr == wr.char_addr)
    else $error("character write without matching mark write");

  a_took_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && took |-> st_r.last_clock && !in_clock_line
      && st_r.bit_count == LAST_BIT)
    else $error("byte executed without eighth falling edge");
`endif

endmodule

// File: sim/serial_alphanumeric_display_controller_tb.sv
// ----------------------------------------------------------------------------
// serial_alphanumeric_display_controller_tb
// Drives serial line samples into the display controller and checks every
// read-back against a cycle-free model of the receiver, byte decoder and
// character/mark stores. Directed bytes cover each control function and the
// mark and reset cases; a long random stream of framed bytes, line noise and
// reset pulses follows, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module serial_alphanumeric_display_controller_tb;
  import sadc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int TARGET_ITEMS = 1450;
  localparam int TAIL_CYCLES  = 8;

  // character remap and segment patterns of the display glyph set
  localparam logic [CHAR_W-1:0] GLYPH_INDEX [64] = '{
     0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15,
    16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 32, 28, 32, 32, 31,
    32, 32, 34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45, 46, 47,
    48, 49, 50, 51, 52, 53, 54, 55, 56, 56, 57, 58, 59, 60, 61, 62
  };
  localparam logic [SEG_W-1:0] GLYPH_SEGMENTS [64] = '{
    20607, 17615,  5439,   243,  4415, 16627, 16579,  1275,
    17612,  4403,   124, 19136,   240, 33484, 35020,   255,
    17607,  2303, 19655, 17595,  4355,   252,  8896, 10444,
    43520, 37376,  8755,   225, 34816,    30, 10240,    48,
        0, 33057,   384, 21820,  4539, 30617, 51577,   512,
     2560, 40960, 65280, 21760,     0, 17408,     0,  8704,
     8959,  4352, 17527, 17471, 17548, 17595, 17659,    15,
    17663, 17599,    33,  8193, 17456, 17456,   786,  5127
  };

  typedef struct {
    logic [SEG_W-1:0]   seg;
    logic [CHAR_W-1:0]  mark;
    logic [LEVEL_W-1:0] bright;
    logic [LEVEL_W-1:0] digits;
    logic               took;
  } readback_t;

  typedef enum int {RX_FREE, RX_COIN, RX_RHYTHM, RX_LONG} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_reset_line = 1'b1;
  logic               in_clock_line = 1'b0;
  logic               in_data_line = 1'b0;
  logic [POS_W-1:0]   in_read_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SEG_W-1:0]   out_segment_pattern;
  logic [CHAR_W-1:0]  out_point_mark;
  logic [LEVEL_W-1:0] out_bright_level;
  logic [LEVEL_W-1:0] out_digits_in_use;
  logic               out_byte_taken;

  serial_alphanumeric_display_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_reset_line       (in_reset_line),
    .in_clock_line       (in_clock_line),
    .in_data_line        (in_data_line),
    .in_read_position    (in_read_position),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_segment_pattern (out_segment_pattern),
    .out_point_mark      (out_point_mark),
    .out_bright_level    (out_bright_level),
    .out_digits_in_use   (out_digits_in_use),
    .out_byte_taken      (out_byte_taken)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // display model state
  logic               line_clk_q;
  logic [2:0]         bit_idx;
  logic [7:0]         shift_acc;
  logic [POS_W-1:0]   cursor_pos;
  logic [POS_W-1:0]   prev_pos;
  logic [LEVEL_W-1:0] digit_cnt;
  logic [LEVEL_W-1:0] bright_lvl;
  logic [CHAR_W-1:0]  char_mem [DIGIT_POSITIONS];
  logic [CHAR_W-1:0]  mark_mem [DIGIT_POSITIONS];

  readback_t readback_q[$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void run_display_byte(logic [7:0] b);
    logic [CHAR_W-1:0] low6;
    low6 = b[5:0];
    if (!b[7]) begin
      if (low6 == MARK_COMMA || low6 == MARK_DOT) begin
        mark_mem[prev_pos] = low6;
      end else begin
        char_mem[cursor_pos] = low6;
        mark_mem[cursor_pos] = MARK_PLAIN;
        prev_pos   = cursor_pos;
        cursor_pos = cursor_pos + 1'b1;
      end
    end else begin
      case (b[6:5])
        CTL_CURSOR: begin
          prev_pos   = cursor_pos;
          cursor_pos = (b[3:0] == NIB_WRAP) ? '0 : b[3:0] + 1'b1;
        end
        CTL_DIGITS: digit_cnt = (b[3:0] == 4'd0) ? DIGITS_RESET : {1'b0, b[3:0]};
        CTL_BRIGHT: bright_lvl = b[4:0];
        default: ;
      endcase
    end
  endfunction

  function automatic void predict_readback(logic rl, logic cl, logic dl, logic [POS_W-1:0] pos);
    readback_t r;
    logic [7:0] b;
    r.took = 1'b0;
    if (!rl) begin
      line_clk_q = cl;
      bit_idx    = '0;
      shift_acc  = '0;
      cursor_pos = '0;
      prev_pos   = '0;
      digit_cnt  = DIGITS_RESET;
      bright_lvl = BRIGHT_RESET;
    end else begin
      if (line_clk_q && !cl) begin
        shift_acc = shift_acc | {7'd0, dl};
        if (bit_idx == LAST_BIT) begin
          b         = shift_acc;
          bit_idx   = '0;
          shift_acc = '0;
          run_display_byte(b);
          r.took = 1'b1;
        end else begin
          bit_idx   = bit_idx + 1'b1;
          shift_acc = shift_acc << 1;
        end
      end
      line_clk_q = cl;
    end
    r.seg    = GLYPH_SEGMENTS[GLYPH_INDEX[char_mem[pos]]];
    r.mark   = mark_mem[pos];
    r.bright = bright_lvl;
    r.digits = digit_cnt;
    readback_q.push_back(r);
  endfunction

  // Enter and leave at a falling edge; the sender may idle between bursts.
  task automatic send_sample(logic rl, logic cl, logic dl, logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_reset_line    <= rl;
    in_clock_line    <= cl;
    in_data_line     <= dl;
    in_read_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_readback(rl, cl, dl, pos);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      repeat ($urandom_range(1, 2))
        send_sample(1'b1, 1'b1, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      send_sample(1'b1, 1'b0, b[i], 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 2) == 0)
        send_sample(1'b1, 1'b0, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    end
  endtask

  function automatic logic [7:0] ctl_byte(logic [1:0] fn, logic [4:0] arg);
    return {1'b1, fn, arg};
  endfunction

  // Hold the sender until every expected read-back has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_char_writes();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte({2'b00, 6'd27});
    send_byte({2'b01, 6'd58});
  endtask

  task automatic test_marks();
    send_byte({2'b00, MARK_COMMA});
    send_byte({2'b01, MARK_DOT});
  endtask

  task automatic test_cursor();
    send_byte(ctl_byte(CTL_CURSOR, {1'b0, NIB_WRAP}));
    send_byte(ctl_byte(CTL_CURSOR, 5'h1E));
    // two writes cross the last position and wrap
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte({2'b00, MARK_DOT});
  endtask

  task automatic test_digit_count();
    send_byte(ctl_byte(CTL_DIGITS, 5'h00));
    send_byte(ctl_byte(CTL_DIGITS, 5'h01));
    send_byte(ctl_byte(CTL_DIGITS, 5'h1F));
  endtask

  task automatic test_brightness();
    send_byte(ctl_byte(CTL_BRIGHT, 5'h00));
    send_byte(ctl_byte(CTL_BRIGHT, 5'h1F));
    send_byte(ctl_byte(CTL_BRIGHT, 5'h0A));
  endtask

  task automatic test_test_mode();
    send_byte(ctl_byte(CTL_TEST, 5'h00));
    send_byte(ctl_byte(CTL_TEST, 5'h1F));
  endtask

  task automatic test_reset_line();
    for (int i = 0; i < 3; i++) begin
      send_sample(1'b1, 1'b1, 1'b1, 4'($urandom_range(0, 15)));
      send_sample(1'b1, 1'b0, 1'b1, 4'($urandom_range(0, 15)));
    end
    // reset ends with the clock line high, so the release sample is a
    // falling edge and shifts the first bit
    send_sample(1'b0, 1'b0, 1'b1, 4'd0);
    send_sample(1'b0, 1'b1, 1'b0, 4'd15);
    send_sample(1'b1, 1'b0, 1'b1, 4'd1);
    send_byte(8'h35);
  endtask

  task automatic test_random_stream();
    int pick;
    int n;
    bit paused;
    paused = 1'b0;
    while (items_sent < TARGET_ITEMS) begin
      if (!paused && items_sent >= TARGET_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_byte({1'b0, 7'($urandom_range(0, 127))});
      end else if (pick < 45) begin
        send_byte({1'b0, 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 1) != 0) ? MARK_COMMA : MARK_DOT});
      end else if (pick < 75) begin
        send_byte({1'b1, 7'($urandom_range(0, 127))});
      end else if (pick < 85) begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_sample(($urandom_range(0, 15) != 0), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end else if (pick < 93) begin
        n = $urandom_range(1, 4);
        repeat (n)
          send_sample(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)));
      end else begin
        // cut a byte short, then resynchronize
        n = $urandom_range(1, 7);
        repeat (n) begin
          send_sample(1'b1, 1'b1, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
          send_sample(1'b1, 1'b0, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end
        send_sample(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)));
      end
    end
  endtask

  // receiver back-pressure in changing patterns
  rx_mode_t rx_mode = RX_FREE;
  int       rx_phase = 0;

  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_mode  = rx_mode_t'($urandom_range(0, 3));
      rx_phase = $urandom_range(16, 96);
    end else begin
      rx_phase--;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_RHYTHM: out_ready <= (rx_phase % 4 != 0);
      default:   out_ready <= ((rx_phase / 8) % 4 == 0);
    endcase
  end

  always @(posedge clk) begin
    readback_t want;
    if (rst_n && out_valid && out_ready) begin
      if (readback_q.size() == 0) begin
        report_mismatch("read-back with no transaction outstanding");
      end else begin
        want = readback_q.pop_front();
        if (out_segment_pattern !== want.seg)
          report_mismatch($sformatf("segment_pattern got %0d expected %0d",
                                    out_segment_pattern, want.seg));
        if (out_point_mark !== want.mark)
          report_mismatch($sformatf("point_mark got %0d expected %0d",
                                    out_point_mark, want.mark));
        if (out_bright_level !== want.bright)
          report_mismatch($sformatf("bright_level got %0d expected %0d",
                                    out_bright_level, want.bright));
        if (out_digits_in_use !== want.digits)
          report_mismatch($sformatf("digits_in_use got %0d expected %0d",
                                    out_digits_in_use, want.digits));
        if (out_byte_taken !== want.took)
          report_mismatch($sformatf("byte_taken got %0d expected %0d",
                                    out_byte_taken, want.took));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    line_clk_q = 1'b0;
    bit_idx    = '0;
    shift_acc  = '0;
    cursor_pos = '0;
    prev_pos   = '0;
    digit_cnt  = DIGITS_RESET;
    bright_lvl = BRIGHT_RESET;
    for (int i = 0; i < DIGIT_POSITIONS; i++) begin
      char_mem[i] = CHAR_SPACE;
      mark_mem[i] = MARK_RESET;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_char_writes();
    test_marks();
    test_cursor();
    test_digit_count();
    test_brightness();
    test_test_mode();
    test_reset_line();
    test_random_stream();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && readback_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
